### src/amsdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amsdu_pkg
// Types, constants and controller codes for the A-MSDU splitter.
// ----------------------------------------------------------------------------
package amsdu_pkg;

  localparam int unsigned HdrLen  = 14;
  localparam int unsigned SnapLen = 6;
  localparam int unsigned HeldLen = 20;
  localparam logic [7:0]  MaxSubframesRst = 8'd64;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StLenOvr  = 2'd1;
  localparam logic [1:0] StPadOvr  = 2'd2;
  localparam logic [1:0] StTooMany = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] body_length;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic [1:0] status;
    logic [7:0] subframe_count;
    logic       run_last;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR, PH_SNAP, PH_MSDU, PH_PAD, PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    CT_TAKE, CT_FLUSH, CT_SUMMARY
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // consume the input byte
    logic flush;     // emit one held byte
    logic summary;   // emit summary
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic flush_pending;  // byte step left held bytes to emit
    logic flush_last;     // current flush byte is the last held one
    logic sum_pending;    // summary owed after flush
    logic out_free;       // output register can take an item
  } sts_t;

endpackage
`default_nettype wire

### src/amsdu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amsdu_ctrl
// Sequencer: byte step, then held-byte flush, then summary.
// ----------------------------------------------------------------------------
module amsdu_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire amsdu_pkg::sts_t sts_i,
  output amsdu_pkg::cmd_t      cmd_o
);

  amsdu_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amsdu_pkg::CT_TAKE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      amsdu_pkg::CT_TAKE: begin
        if (sts_i.flush_pending) state_d = amsdu_pkg::CT_FLUSH;
        else if (sts_i.sum_pending) state_d = amsdu_pkg::CT_SUMMARY;
      end
      amsdu_pkg::CT_FLUSH: begin
        if (sts_i.out_free && sts_i.flush_last) begin
          state_d = sts_i.sum_pending ? amsdu_pkg::CT_SUMMARY : amsdu_pkg::CT_TAKE;
        end
      end
      amsdu_pkg::CT_SUMMARY: begin
        if (sts_i.out_free) state_d = amsdu_pkg::CT_TAKE;
      end
      default: state_d = amsdu_pkg::CT_TAKE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      amsdu_pkg::CT_TAKE: begin
        in_stall_o = !sts_i.out_free || sts_i.flush_pending || sts_i.sum_pending;
        cmd_o.take = in_valid_i && sts_i.out_free && !sts_i.flush_pending &&
                     !sts_i.sum_pending;
      end
      amsdu_pkg::CT_FLUSH:   cmd_o.flush   = sts_i.out_free;
      amsdu_pkg::CT_SUMMARY: cmd_o.summary = sts_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/amsdu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amsdu_dp
// Parse state, held header bytes and the output register.
// ----------------------------------------------------------------------------
module amsdu_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire amsdu_pkg::in_item_t in_data_i,
  input  wire amsdu_pkg::cmd_t     cmd_i,
  output amsdu_pkg::sts_t          sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output amsdu_pkg::out_item_t     out_data_o
);

  logic [7:0] held_q [amsdu_pkg::HeldLen];

  logic [7:0]  max_q, max_d;
  amsdu_pkg::phase_e ph_q, ph_d;
  logic [4:0]  hcnt_q, hcnt_d;
  logic [15:0] brem_q, brem_d;
  logic [15:0] mrem_q, mrem_d;
  logic [1:0]  prem_q, prem_d;
  logic [7:0]  sfd_q, sfd_d;
  logic [1:0]  stp_q, stp_d;
  logic [2:0]  snap_q, snap_d;
  // flush bookkeeping
  logic        fpend_q, fpend_d;
  logic [4:0]  fidx_q, fidx_d;
  logic [4:0]  flen_q, flen_d;
  logic        fdone_q, fdone_d;
  logic        spend_q, spend_d;
  logic [1:0]  sst_q, sst_d;
  logic        wr_en;
  logic [4:0]  wr_idx;

  logic        ov_q, ov_d;
  amsdu_pkg::out_item_t ob_q, ob_d;

  logic out_free;
  assign out_free    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  assign sts_o.flush_pending = fpend_q;
  assign sts_o.flush_last    = (fidx_q == flen_q - 5'd1);
  assign sts_o.sum_pending   = spend_q;
  assign sts_o.out_free      = out_free;

  always_ff @(posedge clk_i) begin
    if (wr_en) held_q[wr_idx] <= in_data_i.data_byte;
  end

  // end of MSDU decision given updated counters
  function automatic void eom(input logic [1:0] stp, input logic [15:0] br,
                              input logic [1:0] pr, output amsdu_pkg::phase_e ph,
                              output logic [1:0] st, output logic [4:0] hc,
                              input logic [4:0] hc0);
    st = stp; hc = hc0;
    if (stp == amsdu_pkg::StTooMany || br == 16'd0) ph = amsdu_pkg::PH_DRAIN;
    else if (br < {14'd0, pr}) begin
      st = amsdu_pkg::StPadOvr; ph = amsdu_pkg::PH_DRAIN;
    end else if (pr != 2'd0) ph = amsdu_pkg::PH_PAD;
    else if (br > 16'(amsdu_pkg::HdrLen)) begin
      ph = amsdu_pkg::PH_HDR; hc = 5'd0;
    end else ph = amsdu_pkg::PH_DRAIN;
  endfunction

  always_comb begin
    logic [15:0] len;
    logic [2:0]  sn;
    logic        emit;
    logic        efs, efe;
    logic [7:0]  eb;
    max_d = cfg_we_i ? cfg_wdata_i : max_q;
    ph_d = ph_q; hcnt_d = hcnt_q; brem_d = brem_q; mrem_d = mrem_q;
    prem_d = prem_q; sfd_d = sfd_q; stp_d = stp_q; snap_d = snap_q;
    fpend_d = fpend_q; fidx_d = fidx_q; flen_d = flen_q; fdone_d = fdone_q;
    spend_d = spend_q; sst_d = sst_q;
    wr_en = 1'b0; wr_idx = hcnt_q;
    ov_d = ov_q && out_stall_i; ob_d = ob_q;
    emit = 1'b0; efs = 1'b0; efe = 1'b0; eb = in_data_i.data_byte;
    len = {held_q[12], held_q[13]};
    sn = 3'd0;

    if (cmd_i.take) begin
      if (in_data_i.first_byte) begin
        brem_d = in_data_i.body_length; mrem_d = '0; prem_d = '0; sfd_d = '0;
        stp_d = amsdu_pkg::StOk; hcnt_d = '0;
        if (in_data_i.body_length < 16'(amsdu_pkg::HdrLen)) begin
          stp_d = amsdu_pkg::StLenOvr; ph_d = amsdu_pkg::PH_DRAIN;
        end else ph_d = amsdu_pkg::PH_HDR;
      end
      wr_idx = hcnt_d;
      case (ph_d)
        amsdu_pkg::PH_HDR: begin
          wr_en = 1'b1; hcnt_d = hcnt_d + 5'd1; brem_d = brem_d - 16'd1;
          if (hcnt_d == 5'(amsdu_pkg::HdrLen)) begin
            // length bytes: byte 12 is held, byte 13 is the input
            len = {held_q[12], in_data_i.data_byte};
            if (len > brem_d) begin
              stp_d = amsdu_pkg::StLenOvr; ph_d = amsdu_pkg::PH_DRAIN;
            end else begin
              if (sfd_d >= max_q) stp_d = amsdu_pkg::StTooMany;
              if (sfd_d != 8'd255) sfd_d = sfd_d + 8'd1;
              mrem_d = len;
              prem_d = 2'(16'd0 - (len + 16'(amsdu_pkg::HdrLen)));
              sn = (len < 16'(amsdu_pkg::SnapLen)) ? len[2:0] : 3'(amsdu_pkg::SnapLen);
              snap_d = sn;
              if (sn == 3'd0) begin
                fpend_d = 1'b1; fidx_d = '0; flen_d = 5'(amsdu_pkg::HdrLen);
                fdone_d = 1'b1;
                eom(stp_d, brem_d, prem_d, ph_d, stp_d, hcnt_d, hcnt_d);
              end else ph_d = amsdu_pkg::PH_SNAP;
            end
          end
        end
        amsdu_pkg::PH_SNAP: begin
          wr_en = 1'b1; hcnt_d = hcnt_d + 5'd1; brem_d = brem_d - 16'd1;
          mrem_d = mrem_d - 16'd1;
          if (hcnt_d >= 5'(amsdu_pkg::HdrLen) + {2'd0, snap_q}) begin
            fpend_d = 1'b1; fdone_d = (mrem_d == 16'd0);
            // snap test needs the final byte; it is the input at index 19
            if (snap_q == 3'(amsdu_pkg::SnapLen) && held_q[14] == 8'hAA &&
                held_q[15] == 8'hAA && held_q[16] == 8'h03 && held_q[17] == 8'h00 &&
                held_q[18] == 8'h00 &&
                (in_data_i.data_byte == 8'h00 || in_data_i.data_byte == 8'hF8)) begin
              fidx_d = 5'd0; flen_d = 5'd12;
            end else begin
              fidx_d = 5'd0; flen_d = 5'(amsdu_pkg::HdrLen) + {2'd0, snap_q};
            end
            if (mrem_d == 16'd0) eom(stp_d, brem_d, prem_d, ph_d, stp_d, hcnt_d, hcnt_d);
            else ph_d = amsdu_pkg::PH_MSDU;
          end
        end
        amsdu_pkg::PH_MSDU: begin
          brem_d = brem_d - 16'd1; mrem_d = mrem_d - 16'd1;
          emit = 1'b1; efe = (mrem_d == 16'd0);
          if (mrem_d == 16'd0) eom(stp_d, brem_d, prem_d, ph_d, stp_d, hcnt_d, hcnt_d);
        end
        amsdu_pkg::PH_PAD: begin
          brem_d = brem_d - 16'd1; prem_d = prem_d - 2'd1;
          if (prem_d == 2'd0) begin
            if (brem_d > 16'(amsdu_pkg::HdrLen)) begin
              ph_d = amsdu_pkg::PH_HDR; hcnt_d = '0;
            end else ph_d = amsdu_pkg::PH_DRAIN;
          end
        end
        default: ;
      endcase
      if (ph_d != amsdu_pkg::PH_IDLE && in_data_i.last_byte) begin
        spend_d = 1'b1;
        sst_d = (ph_d == amsdu_pkg::PH_DRAIN) ? stp_d : amsdu_pkg::StLenOvr;
        ph_d = amsdu_pkg::PH_IDLE;
      end
      if (emit) begin
        ov_d = 1'b1;
        ob_d = '0; ob_d.out_byte = eb; ob_d.frame_start = efs; ob_d.frame_end = efe;
        ob_d.run_last = !spend_d;
      end
    end else if (cmd_i.flush) begin
      ov_d = 1'b1;
      ob_d = '0;
      ob_d.out_byte = held_q[fidx_q];
      ob_d.frame_start = (fidx_q == 5'd0);
      ob_d.frame_end = fdone_q && sts_o.flush_last;
      ob_d.run_last = sts_o.flush_last && !spend_q;
      fidx_d = fidx_q + 5'd1;
      if (sts_o.flush_last) fpend_d = 1'b0;
    end else if (cmd_i.summary) begin
      ov_d = 1'b1;
      ob_d = '0; ob_d.kind = 1'b1; ob_d.status = sst_q; ob_d.subframe_count = sfd_q;
      ob_d.run_last = 1'b1;
      spend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= amsdu_pkg::MaxSubframesRst; ph_q <= amsdu_pkg::PH_IDLE;
      hcnt_q <= '0; brem_q <= '0; mrem_q <= '0; prem_q <= '0; sfd_q <= '0;
      stp_q <= '0; snap_q <= '0; fpend_q <= 1'b0; fidx_q <= '0; flen_q <= '0;
      fdone_q <= 1'b0; spend_q <= 1'b0; sst_q <= '0; ov_q <= 1'b0;
    end else begin
      max_q <= max_d; ph_q <= ph_d; hcnt_q <= hcnt_d; brem_q <= brem_d;
      mrem_q <= mrem_d; prem_q <= prem_d; sfd_q <= sfd_d; stp_q <= stp_d;
      snap_q <= snap_d; fpend_q <= fpend_d; fidx_q <= fidx_d; flen_q <= flen_d;
      fdone_q <= fdone_d; spend_q <= spend_d; sst_q <= sst_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end

endmodule
`default_nettype wire

### src/amsdu_deaggregator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amsdu_deaggregator_unit
// A-MSDU splitter: body bytes in, Ethernet frame bytes and summaries out.
//
// Input channel in_valid_i/in_stall_o carries one body byte per beat, with
// first/last markers and the body length on the first beat. Output channel
// out_valid_o/out_stall_i carries frame bytes and one summary per body.
// An accepted payload byte is registered and presented in the next cycle.
// Input bytes are taken back to back while the output is free; the byte that
// completes a subframe header (or its SNAP check) is followed by a turnaround
// and a flush of 12 to 20 held bytes, and the closing byte by a summary (plus
// a turnaround when no flush precedes it), during which input is stalled.
// Single output register; a stalled receiver holds it and stalls input.
// Reset empties the output, returns to idle and sets max_subframes to 64.
// ----------------------------------------------------------------------------
module amsdu_deaggregator_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire amsdu_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output amsdu_pkg::out_item_t      out_data_o
);

  amsdu_pkg::cmd_t cmd;
  amsdu_pkg::sts_t sts;

  amsdu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  amsdu_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_data_i, .cmd_i(cmd),
    .sts_o(sts), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire

### src/amsdu_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amsdu_chk
// Port-level checks for the A-MSDU splitter.
// ----------------------------------------------------------------------------
module amsdu_chk (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire amsdu_pkg::out_item_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled beat changed");

  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind |-> out_data_o.run_last && !out_data_o.frame_start)
    else $error("bad summary beat");

  a_frm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind |-> out_data_o.status == amsdu_pkg::StOk)
    else $error("status on frame beat");

endmodule

bind amsdu_deaggregator_unit amsdu_chk u_chk (.*);
`default_nettype wire

### bench/amsdu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amsdu_checker
// Watches both channels of the A-MSDU splitter, predicts the frame bytes and
// summaries of each accepted body byte and compares them in order.
// ----------------------------------------------------------------------------
module amsdu_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire amsdu_pkg::in_item_t  in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire amsdu_pkg::out_item_t out_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  amsdu_pkg::out_item_t expected_q[$];
  logic [7:0]  limit_r;
  amsdu_pkg::phase_e phase_r;
  logic [7:0]  held_r[amsdu_pkg::HeldLen];
  int unsigned held_cnt, body_left, msdu_left, pad_left, snap_need;
  logic [7:0]  done_cnt;
  logic [1:0]  stop_r;

  assign pending_o = expected_q.size();

  function automatic amsdu_pkg::out_item_t mk(logic k, logic [7:0] b, logic s, logic e,
                                              logic [1:0] st, logic [7:0] c);
    amsdu_pkg::out_item_t r;
    r.kind = k; r.out_byte = b; r.frame_start = s; r.frame_end = e;
    r.status = st; r.subframe_count = c; r.run_last = 1'b0;
    return r;
  endfunction

  task automatic next_sub();
    if (body_left > amsdu_pkg::HdrLen) begin
      phase_r = amsdu_pkg::PH_HDR;
      held_cnt = 0;
    end else begin
      phase_r = amsdu_pkg::PH_DRAIN;
    end
  endtask

  task automatic msdu_end();
    if (stop_r == amsdu_pkg::StTooMany || body_left == 0) phase_r = amsdu_pkg::PH_DRAIN;
    else if (body_left < pad_left) begin
      stop_r = amsdu_pkg::StPadOvr;
      phase_r = amsdu_pkg::PH_DRAIN;
    end else if (pad_left != 0) phase_r = amsdu_pkg::PH_PAD;
    else next_sub();
  endtask

  task automatic flush(ref amsdu_pkg::out_item_t q[$]);
    int unsigned n;
    bit fin;
    fin = (msdu_left == 0);
    if (snap_need == amsdu_pkg::SnapLen && held_r[14] == 8'hAA && held_r[15] == 8'hAA &&
        held_r[16] == 8'h03 && held_r[17] == 8'h00 && held_r[18] == 8'h00 &&
        (held_r[19] == 8'h00 || held_r[19] == 8'hF8)) n = 12;
    else n = amsdu_pkg::HdrLen + snap_need;
    for (int i = 0; i < n; i++)
      q.push_back(mk(1'b0, held_r[i], i == 0, fin && i == n - 1, amsdu_pkg::StOk, 8'd0));
    if (fin) msdu_end();
    else phase_r = amsdu_pkg::PH_MSDU;
  endtask

  task automatic predict_beat(amsdu_pkg::in_item_t it);
    amsdu_pkg::out_item_t q[$];
    int unsigned len;
    if (it.first_byte) begin
      body_left = it.body_length;
      msdu_left = 0; pad_left = 0; done_cnt = 0; stop_r = amsdu_pkg::StOk; held_cnt = 0;
      if (body_left < amsdu_pkg::HdrLen) begin
        stop_r = amsdu_pkg::StLenOvr;
        phase_r = amsdu_pkg::PH_DRAIN;
      end else phase_r = amsdu_pkg::PH_HDR;
    end
    if (phase_r != amsdu_pkg::PH_IDLE) begin
      case (phase_r)
        amsdu_pkg::PH_HDR: begin
          held_r[held_cnt % amsdu_pkg::HeldLen] = it.data_byte;
          held_cnt++; body_left--;
          if (held_cnt >= amsdu_pkg::HdrLen) begin
            len = {held_r[12], held_r[13]};
            if (len > body_left) begin
              stop_r = amsdu_pkg::StLenOvr;
              phase_r = amsdu_pkg::PH_DRAIN;
            end else begin
              if (done_cnt >= limit_r) stop_r = amsdu_pkg::StTooMany;
              if (done_cnt < 8'd255) done_cnt++;
              msdu_left = len;
              pad_left = (0 - (len + amsdu_pkg::HdrLen)) & 3;
              snap_need = (len < amsdu_pkg::SnapLen) ? len : amsdu_pkg::SnapLen;
              if (snap_need == 0) flush(q);
              else phase_r = amsdu_pkg::PH_SNAP;
            end
          end
        end
        amsdu_pkg::PH_SNAP: begin
          held_r[held_cnt % amsdu_pkg::HeldLen] = it.data_byte;
          held_cnt++; body_left--; msdu_left--;
          if (held_cnt >= amsdu_pkg::HdrLen + snap_need) flush(q);
        end
        amsdu_pkg::PH_MSDU: begin
          body_left--; msdu_left--;
          q.push_back(mk(1'b0, it.data_byte, 1'b0, msdu_left == 0, amsdu_pkg::StOk, 8'd0));
          if (msdu_left == 0) msdu_end();
        end
        amsdu_pkg::PH_PAD: begin
          body_left--; pad_left--;
          if (pad_left == 0) next_sub();
        end
        default: ;
      endcase
      if (it.last_byte) begin
        q.push_back(mk(1'b1, 8'd0, 1'b0, 1'b0,
                       (phase_r == amsdu_pkg::PH_DRAIN) ? stop_r : amsdu_pkg::StLenOvr,
                       done_cnt));
        phase_r = amsdu_pkg::PH_IDLE;
      end
    end
    if (q.size() > 0) q[q.size()-1].run_last = 1'b1;
    foreach (q[i]) expected_q.push_back(q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    amsdu_pkg::out_item_t e;
    if (!rst_ni) begin
      limit_r <= amsdu_pkg::MaxSubframesRst;
      phase_r = amsdu_pkg::PH_IDLE;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) limit_r <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_beat(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected beat %p", out_data_i);
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected %p actual %p", e, out_data_i);
          end
        end
      end
    end
  end
endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives A-MSDU bodies with random stalls and configuration changes between
// phases; the checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_top;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  amsdu_pkg::in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  amsdu_pkg::out_item_t out_data_o;
  int        fail_count, pending_cnt;
  int        idle_cycles = 0;
  bit        calm, hold_rx;
  int        body_cnt;
  logic [7:0] bq[$];

  always #6 clk_i = ~clk_i;

  amsdu_deaggregator_unit i_dut (.*);

  amsdu_checker i_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .in_data_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_data_i(out_data_o), .fail_count_o(fail_count),
    .pending_o(pending_cnt)
  );

  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else out_stall_i <= !calm && ($urandom_range(99) < 21);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(logic [7:0] b, logic f, logic l, logic [15:0] len);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, first_byte: f, last_byte: l, body_length: len};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Build one body of subframes into bq; returns declared length.
  task automatic build_body(int nsub, int maxlen, output int blen);
    int len, pad, k;
    bq.delete();
    for (int s = 0; s < nsub; s++) begin
      len = $urandom_range(maxlen);
      for (int i = 0; i < 12; i++) bq.push_back(8'($urandom));
      bq.push_back(len[15:8]); bq.push_back(len[7:0]);
      k = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        if (k < 2 && i < 6)
          bq.push_back(i < 2 ? 8'hAA : i == 2 ? 8'h03 :
                       i == 5 ? (k == 0 ? 8'h00 : 8'hF8) : 8'h00);
        else bq.push_back(8'($urandom));
      end
      pad = (0 - (len + 14)) & 3;
      if (s != nsub - 1) for (int i = 0; i < pad; i++) bq.push_back(8'($urandom));
    end
    blen = bq.size();
  endtask

  task automatic send_body(int nsub, int maxlen, int mode);
    int blen, n;
    logic [15:0] dl;
    build_body(nsub, maxlen, blen);
    dl = 16'(blen);
    n = blen;
    case (mode)
      1: n = $urandom_range(blen > 1 ? blen - 1 : 1, 1);
      2: begin n = blen + $urandom_range(4); dl = 16'(blen); end
      3: dl = 16'($urandom);
      4: dl = 16'($urandom_range(13));
      default: ;
    endcase
    for (int i = 0; i < n; i++)
      send(i < blen ? bq[i] : 8'($urandom), i == 0, i == n - 1, dl);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] v);
    settle();
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    calm = 1;
    send(8'hFF, 1'b0, 1'b0, 16'hFFFF);
    send_body(1, 8, 0);
    send_body(1, 0, 0);
    calm = 0;
    send_body(1, 10, 4);
    send(8'h00, 1'b1, 1'b1, 16'h0000);
    send(8'hFF, 1'b1, 1'b1, 16'hFFFF);
    write_limit(8'd0);
    send_body(2, 4, 0);
    write_limit(8'd1);
    send_body(2, 4, 0);
    write_limit(8'd255);
    hold_rx = 1;
    fork
      send_body(1, 24, 0);
      begin repeat (300) @(posedge clk_i); hold_rx = 0; end
    join
    settle();
    body_cnt = 0;
    repeat (2) begin
      if (body_cnt == 1) write_limit(8'($urandom_range(1, 3)));
      if ($urandom_range(9) < 7) send_body(1, 6, 0);
      else send_body(1, 6, $urandom_range(1, 4));
      if ($urandom_range(9) == 0) send(8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
      body_cnt++;
    end
    calm = 0;
    settle();
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
